[src/wstb_pkg.sv]
// windowed sine tone burst: shared types, register indexes and the sine table builder
// no dependencies; imported by every module of the block except wstb_queue
package wstb_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TONE_STEP    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_STEP  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BURST_LENGTH = 2'd2;

   // register reset values
   localparam logic [31:0] TONE_STEP_RESET    = 32'd42949673;
   localparam logic [31:0] WINDOW_STEP_RESET  = 32'd97391;
   localparam logic [23:0] BURST_LENGTH_RESET = 24'd44100;

   // field widths
   localparam int INDEX_WIDTH  = 24;
   localparam int SAMPLE_WIDTH = 16;
   localparam int TABLE_WIDTH  = 15;

   // pi/2 in Q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // taylor series divisors (2n)(2n+1) for n = 1..8
   localparam logic [63:0] TAYLOR_DIV [8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   // per-request status that travels with the request through the back end
   typedef struct packed {
      logic last;
      logic done;
   } wstb_flags_type;

   // unsigned q0.15 sine of a q2.30 angle, series through x^17, rounded and saturated
   function automatic logic [TABLE_WIDTH-1:0] sine_q15(input logic [63:0] x);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / TAYLOR_DIV[n-1];
         if ((n % 2) == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + 64'd16384) >> 15;
      return (r > 64'd32767) ? 15'd32767 : r[TABLE_WIDTH-1:0];
   endfunction

endpackage

[src/wstb_queue.sv]
// wstb_queue: small first-in first-out queue between the front and back ends
// depends on nothing outside itself
module wstb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]       entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/wstb_front.sv]
// wstb_front: configuration registers, burst position and phase accumulators
// depends on wstb_pkg; feeds classified requests into wstb_queue
module wstb_front
   import wstb_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration writes
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   // sample requests
   input  logic                       req_valid,
   input  logic                       req_restart,
   output logic                       req_ready,
   // queue side
   input  logic                       queue_full,
   output logic                       push,
   output wstb_flags_type             push_flags,
   output logic [PHASE_BITS-1:0]      push_tone_phase,
   output logic [PHASE_BITS-1:0]      push_envelope_phase
);

   localparam int SUM_WIDTH = (PHASE_BITS > 32) ? PHASE_BITS : 32;

   logic [31:0]            tone_step_ff;
   logic [31:0]            window_step_ff;
   logic [INDEX_WIDTH-1:0] burst_length_ff;
   logic [INDEX_WIDTH-1:0] sample_index_ff, sample_index_in;
   logic [PHASE_BITS-1:0]  tone_phase_ff, tone_phase_in;
   logic [PHASE_BITS-1:0]  envelope_phase_ff, envelope_phase_in;

   logic [INDEX_WIDTH-1:0] index_now;
   logic [PHASE_BITS-1:0]  tone_now, envelope_now;
   logic [SUM_WIDTH-1:0]   tone_sum, envelope_sum;
   logic                   accept;
   logic                   finished;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   // restart clears position and phases before this request is classified
   assign index_now    = req_restart ? '0 : sample_index_ff;
   assign tone_now     = req_restart ? '0 : tone_phase_ff;
   assign envelope_now = req_restart ? '0 : envelope_phase_ff;

   assign finished        = (index_now >= burst_length_ff);
   assign push_flags.done = finished;
   assign push_flags.last = !finished &&
                            (({1'b0, index_now} + 25'd1) == {1'b0, burst_length_ff});
   assign push_tone_phase     = tone_now;
   assign push_envelope_phase = envelope_now;

   // phase accumulators wrap modulo the phase width
   assign tone_sum     = SUM_WIDTH'(tone_now) + SUM_WIDTH'(tone_step_ff);
   assign envelope_sum = SUM_WIDTH'(envelope_now) + SUM_WIDTH'(window_step_ff);

   // next burst state for an accepted request
   always_comb begin
      sample_index_in   = sample_index_ff;
      tone_phase_in     = tone_phase_ff;
      envelope_phase_in = envelope_phase_ff;
      if (accept) begin
         sample_index_in   = index_now;
         tone_phase_in     = tone_now;
         envelope_phase_in = envelope_now;
         if (!finished) begin
            sample_index_in   = index_now + 1'b1;
            tone_phase_in     = tone_sum[PHASE_BITS-1:0];
            envelope_phase_in = envelope_sum[PHASE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff   <= BURST_LENGTH_RESET;
         tone_phase_ff     <= '0;
         envelope_phase_ff <= '0;
      end else begin
         sample_index_ff   <= sample_index_in;
         tone_phase_ff     <= tone_phase_in;
         envelope_phase_ff <= envelope_phase_in;
      end
   end

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_step_ff    <= TONE_STEP_RESET;
         window_step_ff  <= WINDOW_STEP_RESET;
         burst_length_ff <= BURST_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TONE_STEP:    tone_step_ff    <= csr_wdata[31:0];
            CSR_WINDOW_STEP:  window_step_ff  <= csr_wdata[31:0];
            CSR_BURST_LENGTH: burst_length_ff <= csr_wdata[INDEX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

endmodule

[src/wstb_back.sv]
// wstb_back: quarter-wave lookup, envelope multiply and result register
// depends on wstb_pkg; drains requests from wstb_queue
module wstb_back
   import wstb_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   // queue side
   input  logic                    queue_empty,
   input  wstb_flags_type          head_flags,
   input  logic [PHASE_BITS-1:0]   head_tone_phase,
   input  logic [PHASE_BITS-1:0]   head_envelope_phase,
   output logic                    pop,
   // results
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample,
   output logic                    rsp_last,
   output logic                    rsp_done
);

   localparam int FULL_POS   = 4 * SINE_TABLE_DEPTH;
   localparam int POS_WIDTH  = $clog2(FULL_POS);
   localparam int PROD_WIDTH = PHASE_BITS + POS_WIDTH;
   localparam int K_WIDTH    = $clog2(SINE_TABLE_DEPTH);
   localparam int ADDR_WIDTH = $clog2(SINE_TABLE_DEPTH + 1);

   // quarter-wave table, built at elaboration
   logic [TABLE_WIDTH-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] ANGLE = HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
      assign sine_rom[k] = sine_q15(ANGLE);
   end

   logic advance;

   // stage 1: table position of each phase
   logic                  v1_ff;
   wstb_flags_type        flags1_ff;
   logic [POS_WIDTH-1:0]  tone_pos_ff, envelope_pos_ff;
   logic [PROD_WIDTH-1:0] tone_prod, envelope_prod;

   // stage 2: quadrant and table address
   logic                  v2_ff;
   wstb_flags_type        flags2_ff;
   logic [ADDR_WIDTH-1:0] sin_addr_ff, sin_addr_in;
   logic [ADDR_WIDTH-1:0] cos_addr_ff, cos_addr_in;
   logic                  sin_neg2_ff, sin_neg_in;
   logic                  cos_neg2_ff, cos_neg_in;

   // stage 3: table read
   logic                   v3_ff;
   wstb_flags_type         flags3_ff;
   logic [TABLE_WIDTH-1:0] sin_mag_ff, cos_mag_ff;
   logic                   sin_neg3_ff, cos_neg3_ff;

   // stage 4: envelope times sine
   logic               v4_ff;
   wstb_flags_type     flags4_ff;
   logic signed [15:0] sin_val, cos_val;
   logic signed [16:0] envelope;
   logic signed [32:0] mix_ff, mix_in;

   // stage 5: scale by 32767
   logic               v5_ff;
   wstb_flags_type     flags5_ff;
   logic signed [47:0] scaled_ff, scaled_in;

   // output register
   logic                    rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                    rsp_last_ff, rsp_done_ff;
   logic [47:0]             scaled_abs;
   logic [16:0]             trunc_mag;
   logic [16:0]             signed_res;

   // whole back end moves together unless the result is held
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && !queue_empty;

   // position = phase * 4 * depth / 2^phase_bits
   assign tone_prod     = PROD_WIDTH'(head_tone_phase) * PROD_WIDTH'(FULL_POS);
   assign envelope_prod = PROD_WIDTH'(head_envelope_phase) * PROD_WIDTH'(FULL_POS);

   // split a position into quadrant and offset
   function automatic logic [1:0] quadrant_of(input logic [POS_WIDTH-1:0] q);
      if (q >= POS_WIDTH'(3 * SINE_TABLE_DEPTH)) begin
         return 2'd3;
      end else if (q >= POS_WIDTH'(2 * SINE_TABLE_DEPTH)) begin
         return 2'd2;
      end else if (q >= POS_WIDTH'(SINE_TABLE_DEPTH)) begin
         return 2'd1;
      end
      return 2'd0;
   endfunction

   // offset within the position's own quadrant, mirrored for odd read quadrants
   function automatic logic [ADDR_WIDTH-1:0] address_of(input logic [POS_WIDTH-1:0] q,
                                                        input logic [1:0] quad,
                                                        input logic mirror);
      logic [POS_WIDTH-1:0] base;
      logic [K_WIDTH-1:0]   k;
      case (quad)
         2'd3:    base = POS_WIDTH'(3 * SINE_TABLE_DEPTH);
         2'd2:    base = POS_WIDTH'(2 * SINE_TABLE_DEPTH);
         2'd1:    base = POS_WIDTH'(SINE_TABLE_DEPTH);
         default: base = '0;
      endcase
      k = K_WIDTH'(q - base);
      return mirror ? ADDR_WIDTH'(SINE_TABLE_DEPTH) - ADDR_WIDTH'(k) : ADDR_WIDTH'(k);
   endfunction

   // cosine reads one quadrant ahead at the same offset
   always_comb begin
      logic [1:0] sin_quad;
      logic [1:0] env_quad;
      logic [1:0] cos_quad;
      sin_quad    = quadrant_of(tone_pos_ff);
      env_quad    = quadrant_of(envelope_pos_ff);
      cos_quad    = env_quad + 2'd1;
      sin_addr_in = address_of(tone_pos_ff, sin_quad, sin_quad[0]);
      cos_addr_in = address_of(envelope_pos_ff, env_quad, cos_quad[0]);
      sin_neg_in  = sin_quad[1];
      cos_neg_in  = cos_quad[1];
   end

   // envelope 32768 - cos in q0.16, then times sine
   assign sin_val  = sin_neg3_ff ? -$signed({1'b0, sin_mag_ff}) : $signed({1'b0, sin_mag_ff});
   assign cos_val  = cos_neg3_ff ? -$signed({1'b0, cos_mag_ff}) : $signed({1'b0, cos_mag_ff});
   assign envelope = 17'sd32768 - 17'(cos_val);
   assign mix_in   = 33'(envelope) * 33'(sin_val);

   // times 32767 as a shift and subtract
   assign scaled_in = (48'(mix_ff) <<< 15) - 48'(mix_ff);

   // truncate toward zero: shift the magnitude, restore the sign
   assign scaled_abs    = scaled_ff[47] ? 48'(-scaled_ff) : 48'(scaled_ff);
   assign trunc_mag     = scaled_abs[47:31];
   assign signed_res    = scaled_ff[47] ? 17'(-trunc_mag) : trunc_mag;
   assign rsp_sample_in = flags5_ff.done ? '0 : signed_res[SAMPLE_WIDTH-1:0];

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         flags1_ff       <= head_flags;
         tone_pos_ff     <= tone_prod[PHASE_BITS +: POS_WIDTH];
         envelope_pos_ff <= envelope_prod[PHASE_BITS +: POS_WIDTH];

         flags2_ff   <= flags1_ff;
         sin_addr_ff <= sin_addr_in;
         cos_addr_ff <= cos_addr_in;
         sin_neg2_ff <= sin_neg_in;
         cos_neg2_ff <= cos_neg_in;

         flags3_ff   <= flags2_ff;
         sin_mag_ff  <= sine_rom[sin_addr_ff];
         cos_mag_ff  <= sine_rom[cos_addr_ff];
         sin_neg3_ff <= sin_neg2_ff;
         cos_neg3_ff <= cos_neg2_ff;

         flags4_ff <= flags3_ff;
         mix_ff    <= mix_in;

         flags5_ff <= flags4_ff;
         scaled_ff <= scaled_in;

         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= flags5_ff.last;
         rsp_done_ff   <= flags5_ff.done;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_done   = rsp_done_ff;

endmodule

[src/windowed_sine_tone_burst_top.sv]
// windowed_sine_tone_burst_top: top level of the windowed sine tone burst generator
// depends on wstb_pkg, wstb_front, wstb_queue and wstb_back
//
// Each request on req_ yields one signed 16-bit sample on rsp_: a sine at the
// tone step times a periodic Hann envelope over the burst, scaled by 32767 and
// truncated toward zero. Setting restart (req_tdata bit 0) starts the burst over
// at sample zero. rsp_tlast marks the final sample of the burst; past the end the
// sample is zero and rsp_tuser is set. The front end updates the burst position
// and both phase accumulators in the cycle a request is taken, so one request is
// accepted per clock while the four-entry queue has room. The back end is a
// six-register pipeline (position, quadrant, table read, two multiplies, result)
// that delivers one sample per clock while results are taken, and a held result
// stalls the whole back end. Registers are to be written through csr_ only while
// no request is in flight; the block itself does not enforce this.
module windowed_sine_tone_burst_top
   import wstb_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   // requests
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] restart, [7:1] zero
   // results
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // [15:0] sample
   output logic                       rsp_tlast,
   output logic                       rsp_tuser    // [0] done_res
);

   localparam int QUEUE_DEPTH = 4;
   localparam int FLAGS_WIDTH = $bits(wstb_flags_type);
   localparam int ENTRY_WIDTH = FLAGS_WIDTH + 2 * PHASE_BITS;

   logic                  push, pop;
   logic                  queue_full, queue_empty;
   wstb_flags_type        push_flags, head_flags;
   logic [PHASE_BITS-1:0] push_tone_phase, push_envelope_phase;
   logic [PHASE_BITS-1:0] head_tone_phase, head_envelope_phase;
   logic [ENTRY_WIDTH-1:0] push_entry, head_entry;

   // request classification and burst state
   wstb_front #(
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_tvalid),
      .req_restart         (req_tdata[0]),
      .req_ready           (req_tready),
      .queue_full          (queue_full),
      .push                (push),
      .push_flags          (push_flags),
      .push_tone_phase     (push_tone_phase),
      .push_envelope_phase (push_envelope_phase)
   );

   // queue between front and back ends
   assign push_entry = {push_flags, push_tone_phase, push_envelope_phase};
   assign {head_flags, head_tone_phase, head_envelope_phase} = head_entry;

   wstb_queue #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .head_data (head_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // sample computation
   wstb_back #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_BITS       (PHASE_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_empty         (queue_empty),
      .head_flags          (head_flags),
      .head_tone_phase     (head_tone_phase),
      .head_envelope_phase (head_envelope_phase),
      .pop                 (pop),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_sample          (rsp_tdata),
      .rsp_last            (rsp_tlast),
      .rsp_done            (rsp_tuser)
   );

endmodule

[verif/windowed_sine_tone_burst_top_tb.sv]
// windowed_sine_tone_burst_top_tb: self-checking bench for the tone burst generator
// depends on wstb_pkg for register indexes and reset values, and on windowed_sine_tone_burst_top

// one expected sample as it leaves the block
typedef struct packed {
   logic [15:0] sample;
   logic        last;
   logic        done;
} burst_sample_type;

// predicts every sample from its own copy of the registers and accumulators
class tone_burst_scoreboard;
   localparam int QUARTER_DEPTH = 1024;

   int               quarter_wave [QUARTER_DEPTH+1];
   logic [31:0]      tone_step;
   logic [31:0]      window_step;
   logic [23:0]      burst_length;
   logic [31:0]      tone_phase;
   logic [31:0]      envelope_phase;
   logic [23:0]      sample_index;
   burst_sample_type expected_samples [$];
   int               errors;

   function new();
      longint unsigned angle;
      // quarter wave in q1.15 from a q2.30 angle
      for (int k = 0; k <= QUARTER_DEPTH; k++) begin
         angle = (wstb_pkg::HALF_PI_Q30 * longint'(k)) / QUARTER_DEPTH;
         quarter_wave[k] = taylor_sine(angle);
      end
      tone_step      = wstb_pkg::TONE_STEP_RESET;
      window_step    = wstb_pkg::WINDOW_STEP_RESET;
      burst_length   = wstb_pkg::BURST_LENGTH_RESET;
      tone_phase     = '0;
      envelope_phase = '0;
      sample_index   = wstb_pkg::BURST_LENGTH_RESET;
      errors         = 0;
   endfunction

   // odd series through x^17, every term truncated, rounded half up at the end
   function int taylor_sine(longint unsigned x);
      longint unsigned term;
      longint unsigned sum;
      longint unsigned rounded;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      rounded = (sum + 64'd16384) >> 15;
      return (rounded > 64'd32767) ? 32767 : int'(rounded);
   endfunction

   // signed sine at a 12-bit position around the full circle
   function int sine_at(logic [11:0] pos);
      int k;
      k = int'(pos[9:0]);
      case (pos[11:10])
         2'd0: return quarter_wave[k];
         2'd1: return quarter_wave[QUARTER_DEPTH - k];
         2'd2: return -quarter_wave[k];
         default: return -quarter_wave[QUARTER_DEPTH - k];
      endcase
   endfunction

   function void write_register(logic [1:0] index, logic [31:0] data);
      case (index)
         wstb_pkg::CSR_TONE_STEP:    tone_step    = data;
         wstb_pkg::CSR_WINDOW_STEP:  window_step  = data;
         wstb_pkg::CSR_BURST_LENGTH: burst_length = data[23:0];
         default: ;
      endcase
   endfunction

   function bit burst_finished();
      return sample_index >= burst_length;
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction

   // accepted request: advance the burst and queue the sample it yields
   function void note_request(logic restart);
      burst_sample_type want;
      int               s;
      int               c;
      longint           prod;
      longint           mag;
      if (restart) begin
         tone_phase     = '0;
         envelope_phase = '0;
         sample_index   = '0;
      end
      want = '0;
      if (sample_index >= burst_length) begin
         want.done = 1'b1;
      end else begin
         s    = sine_at(tone_phase[31:20]);
         c    = sine_at(envelope_phase[31:20] + 12'd1024);
         prod = longint'(32767) * longint'(32768 - c) * longint'(s);
         mag  = (prod < 0) ? -prod : prod;
         mag  = mag >> 31;
         prod = (prod < 0) ? -mag : mag;
         want.sample    = prod[15:0];
         want.last      = (({1'b0, sample_index} + 25'd1) == {1'b0, burst_length});
         sample_index   = sample_index + 24'd1;
         tone_phase     = tone_phase + tone_step;
         envelope_phase = envelope_phase + window_step;
      end
      expected_samples.push_back(want);
   endfunction

   // compare one delivered sample with the oldest prediction
   function void check_sample(logic [15:0] sample, logic last, logic done);
      burst_sample_type want;
      if (expected_samples.size() == 0) begin
         errors++;
         $display("%0t: unexpected sample %h last %b done %b", $time, sample, last, done);
         return;
      end
      want = expected_samples.pop_front();
      if (sample !== want.sample) begin
         errors++;
         $display("%0t: sample expected %0d got %0d", $time,
                  $signed(want.sample), $signed(sample));
      end
      if (last !== want.last) begin
         errors++;
         $display("%0t: last expected %b got %b", $time, want.last, last);
      end
      if (done !== want.done) begin
         errors++;
         $display("%0t: done expected %b got %b", $time, want.done, done);
      end
   endfunction
endclass

module windowed_sine_tone_burst_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wstb_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_REQUESTS = 1600;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = '0;   // [0] restart, [7:1] zero
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [15:0]                rsp_tdata;         // [15:0] sample
   logic                       rsp_tlast;
   logic                       rsp_tuser;         // [0] done_res

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;

   tone_burst_scoreboard scoreboard = new();

   windowed_sine_tone_burst_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // result side: check on handshake, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_sample(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // run time limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // one request, with random gaps before it; valid stays high afterwards
   task automatic send_request(input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (req_tready !== 1'b1);
      scoreboard.note_request(restart);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      scoreboard.write_register(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // hold off requests until every sample is back and the pipeline is empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      logic        restart;
      logic [31:0] tone;
      logic [31:0] window;
      logic [23:0] length;
      int          pick;
      int          sent;
      int          segment;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // burst already over after reset, then a restart at reset settings
      send_request(1'b0);
      send_request(1'b1);
      repeat (3) send_request(1'b0);

      // quarter-turn tone with half-turn window: positive peak, end of burst, done
      wait_idle();
      write_csr(CSR_TONE_STEP, 32'h4000_0000);
      write_csr(CSR_WINDOW_STEP, 32'h8000_0000);
      write_csr(CSR_BURST_LENGTH, 32'hFF00_0004);
      send_request(1'b1);
      repeat (4) send_request(1'b0);

      // negative peak
      wait_idle();
      write_csr(CSR_TONE_STEP, 32'hC000_0000);
      send_request(1'b1);
      repeat (3) send_request(1'b0);

      // unmapped index ignored, zero length means always done
      wait_idle();
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      write_csr(CSR_BURST_LENGTH, 32'h0000_0000);
      send_request(1'b1);
      send_request(1'b0);

      // raising the length resumes the burst, full-scale tone step and zero window step
      wait_idle();
      write_csr(CSR_TONE_STEP, 32'hFFFF_FFFF);
      write_csr(CSR_WINDOW_STEP, 32'h0000_0000);
      write_csr(CSR_BURST_LENGTH, 32'hFFFF_FFFF);
      repeat (3) send_request(1'b0);

      // lowering the length below the position ends it; one-sample burst
      wait_idle();
      write_csr(CSR_BURST_LENGTH, 32'h0000_0001);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);

      // random bursts under three idle patterns
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 70 : 0;
         recv_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 31 : 0;
         sent = 0;
         while (sent < RANDOM_REQUESTS / 3) begin
            wait_idle();

            // mostly short bursts, a few empty or huge ones
            pick = $urandom_range(99);
            if (pick < 60) begin
               length = 24'($urandom_range(40, 1));
            end else if (pick < 75) begin
               length = 24'($urandom_range(3, 0));
            end else if (pick < 92) begin
               length = 24'($urandom_range(400, 41));
            end else begin
               length = 24'hFFFFFF - 24'($urandom_range(3));
            end
            pick = $urandom_range(9);
            tone = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
            pick = $urandom_range(9);
            if (pick < 5 && length != 0) begin
               window = 32'((64'h1_0000_0000) / length);
            end else if (pick < 7) begin
               window = (pick == 5) ? 32'h0 : 32'hFFFF_FFFF;
            end else begin
               window = $urandom;
            end
            if ($urandom_range(3) != 0) write_csr(CSR_TONE_STEP, tone);
            if ($urandom_range(3) != 0) write_csr(CSR_WINDOW_STEP, window);
            if ($urandom_range(9) == 0) write_csr(CSR_UNMAPPED, $urandom);
            write_csr(CSR_BURST_LENGTH, {8'($urandom), length});

            // a run of requests, restarting mostly once the burst has ended
            segment = $urandom_range(120, 30);
            for (int i = 0; i < segment; i++) begin
               if (scoreboard.burst_finished()) begin
                  restart = ($urandom_range(9) < 6);
               end else begin
                  restart = ($urandom_range(99) < 3);
               end
               if ($urandom_range(299) == 0) wait_idle();
               send_request(restart);
               sent++;
            end
         end
      end

      // drain and look for stray samples
      wait_idle();
      repeat (20) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
